@@ rtl/core/wsfd_pkg.sv @@
// Shared types and constants for the WebSocket frame deframer.
`timescale 1ns / 1ps

package wsfd_pkg;

  // Requested width of the payload length; the supported width LEN_W is capped at 63 bits.
  localparam int LENGTH_BITS = 64;
  localparam int LEN_W       = (LENGTH_BITS >= 63) ? 63 : LENGTH_BITS;
  localparam logic [62:0] LEN_LIMIT = 63'((64'(1) << LEN_W) - 64'(1));

  localparam logic [6:0] LEN7_MAX_SHORT = 7'd125;
  localparam logic [6:0] LEN7_EXT16     = 7'd126;
  localparam logic [3:0] EXT16_BYTES    = 4'd2;
  localparam logic [3:0] EXT64_BYTES    = 4'd8;
  localparam logic [3:0] KEY_BYTES      = 4'd4;

  typedef enum logic [2:0] {
    PH_FIRST   = 3'd0,
    PH_SECOND  = 3'd1,
    PH_EXT     = 3'd2,
    PH_KEY     = 3'd3,
    PH_PAYLOAD = 3'd4
  } phase_t;

  typedef enum logic [1:0] {
    KIND_HEADER = 2'd0,
    KIND_DATA   = 2'd1,
    KIND_ERROR  = 2'd2
  } kind_t;

  typedef struct packed {
    kind_t       kind;
    logic [3:0]  frame_opcode;
    logic [62:0] frame_length;
    logic [7:0]  payload_byte;
    logic        last;
  } result_t;

endpackage

@@ rtl/core/websocket_frame_deframer_unit.sv @@
// WebSocket frame deframer: parses header bytes and unmasks payload, one byte per cycle unless stalled.
`timescale 1ns / 1ps

// Takes one stream byte per cycle while in_stall is low and returns at most one
// registered result per byte: a header item (kind 0) once the length and
// optional mask key are read, an error item (kind 2) in its place when FIN is
// clear, and one unmasked payload item (kind 1) per payload byte, with last on
// the final item of a frame. Payload bytes of a frame with FIN clear produce no
// items. Each byte passes through a single header-decode and XOR step, so the
// sustained rate is one byte per cycle unless in_stall holds it. Results sit in an
// output register backed by one skid entry; in_stall rises only while that skid
// entry is full. Bit 63 of a length is dropped, then it is clamped to 2^LEN_W - 1.
module websocket_frame_deframer_unit (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  in_data_byte,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [1:0]  out_kind,
  output logic [3:0]  out_frame_opcode,
  output logic [62:0] out_frame_length,
  output logic [7:0]  out_payload_byte,
  output logic        out_last
);

  wsfd_pkg::phase_t phase_r, phase_nxt;
  logic [3:0]  header_count_r, header_count_nxt;
  logic [3:0]  opcode_r, opcode_nxt;
  logic        masked_r, masked_nxt;
  logic        fin_error_r, fin_error_nxt;
  logic [31:0] mask_key_r, mask_key_nxt;
  logic [63:0] length_r, length_nxt;
  logic [wsfd_pkg::LEN_W-1:0] remaining_r, remaining_nxt;
  logic [1:0]  key_index_r, key_index_nxt;

  wsfd_pkg::result_t res, out_r, skid_r;
  logic res_valid;
  logic out_valid_r, skid_valid_r;

  logic in_acc, out_take;
  logic [63:0] ext_shift;
  logic [31:0] key_shift;
  logic [3:0]  count_dec;
  logic [62:0] sat_len;
  logic [wsfd_pkg::LEN_W-1:0] remaining_dec;
  logic [7:0]  key_byte;
  logic        finish;
  logic        need_key;

  assign in_stall = skid_valid_r;
  assign in_acc   = in_valid && !skid_valid_r;
  assign out_take = out_valid_r && !out_stall;

  assign ext_shift     = {length_r[55:0], in_data_byte};
  assign key_shift     = {mask_key_r[23:0], in_data_byte};
  assign count_dec     = header_count_r - 4'd1;
  assign remaining_dec = remaining_r - wsfd_pkg::LEN_W'(1);
  assign key_byte      = mask_key_r[5'd31 - {key_index_r, 3'b000} -: 8];

  always_comb begin
    phase_nxt        = phase_r;
    header_count_nxt = header_count_r;
    opcode_nxt       = opcode_r;
    masked_nxt       = masked_r;
    fin_error_nxt    = fin_error_r;
    mask_key_nxt     = mask_key_r;
    length_nxt       = length_r;
    remaining_nxt    = remaining_r;
    key_index_nxt    = key_index_r;
    res_valid        = 1'b0;
    finish           = 1'b0;
    need_key         = 1'b0;
    res.kind         = wsfd_pkg::KIND_HEADER;
    res.frame_opcode = opcode_r;
    res.frame_length = length_r[62:0];
    res.payload_byte = 8'd0;
    res.last         = 1'b0;

    unique case (phase_r)
      wsfd_pkg::PH_SECOND: begin
        masked_nxt   = in_data_byte[7];
        mask_key_nxt = 32'd0;
        if (in_data_byte[6:0] <= wsfd_pkg::LEN7_MAX_SHORT) begin
          length_nxt = {57'd0, in_data_byte[6:0]};
          need_key   = in_data_byte[7];
          finish     = !in_data_byte[7];
        end else begin
          length_nxt       = 64'd0;
          header_count_nxt = (in_data_byte[6:0] == wsfd_pkg::LEN7_EXT16) ?
                             wsfd_pkg::EXT16_BYTES : wsfd_pkg::EXT64_BYTES;
          phase_nxt        = wsfd_pkg::PH_EXT;
        end
      end
      wsfd_pkg::PH_EXT: begin
        length_nxt       = ext_shift;
        header_count_nxt = count_dec;
        if (count_dec == 4'd0) begin
          need_key = masked_r;
          finish   = !masked_r;
        end
      end
      wsfd_pkg::PH_KEY: begin
        mask_key_nxt     = key_shift;
        header_count_nxt = count_dec;
        finish           = (count_dec == 4'd0);
      end
      wsfd_pkg::PH_PAYLOAD: begin
        remaining_nxt = remaining_dec;
        key_index_nxt = key_index_r + 2'd1;
        if (remaining_dec == '0) phase_nxt = wsfd_pkg::PH_FIRST;
        res_valid        = !fin_error_r;
        res.kind         = wsfd_pkg::KIND_DATA;
        res.payload_byte = in_data_byte ^ key_byte;
        res.last         = (remaining_dec == '0);
      end
      default: begin
        fin_error_nxt    = !in_data_byte[7];
        opcode_nxt       = in_data_byte[3:0];
        masked_nxt       = 1'b0;
        mask_key_nxt     = 32'd0;
        length_nxt       = 64'd0;
        remaining_nxt    = '0;
        key_index_nxt    = 2'd0;
        header_count_nxt = 4'd0;
        phase_nxt        = wsfd_pkg::PH_SECOND;
      end
    endcase

    if (need_key) begin
      phase_nxt        = wsfd_pkg::PH_KEY;
      header_count_nxt = wsfd_pkg::KEY_BYTES;
    end

    // Bit 63 of a long length is reserved; clamp to the supported range.
    sat_len = (length_nxt[62:0] > wsfd_pkg::LEN_LIMIT) ? wsfd_pkg::LEN_LIMIT
                                                       : length_nxt[62:0];
    if (finish) begin
      length_nxt       = {1'b0, sat_len};
      remaining_nxt    = wsfd_pkg::LEN_W'(sat_len);
      key_index_nxt    = 2'd0;
      header_count_nxt = 4'd0;
      phase_nxt        = (sat_len != 63'd0) ? wsfd_pkg::PH_PAYLOAD : wsfd_pkg::PH_FIRST;
      res_valid        = 1'b1;
      res.frame_length = sat_len;
      res.payload_byte = 8'd0;
      if (fin_error_r) begin
        res.kind = wsfd_pkg::KIND_ERROR;
        res.last = 1'b1;
      end else begin
        res.kind = wsfd_pkg::KIND_HEADER;
        res.last = (sat_len == 63'd0);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r        <= wsfd_pkg::PH_FIRST;
      header_count_r <= 4'd0;
      opcode_r       <= 4'd0;
      masked_r       <= 1'b0;
      fin_error_r    <= 1'b0;
      mask_key_r     <= 32'd0;
      length_r       <= 64'd0;
      remaining_r    <= '0;
      key_index_r    <= 2'd0;
    end else if (in_acc) begin
      phase_r        <= phase_nxt;
      header_count_r <= header_count_nxt;
      opcode_r       <= opcode_nxt;
      masked_r       <= masked_nxt;
      fin_error_r    <= fin_error_nxt;
      mask_key_r     <= mask_key_nxt;
      length_r       <= length_nxt;
      remaining_r    <= remaining_nxt;
      key_index_r    <= key_index_nxt;
    end
  end

  // Output register plus one skid entry: refill from skid first, else take the new item.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else if (out_take || !out_valid_r) begin
      if (skid_valid_r) begin
        out_valid_r  <= 1'b1;
        skid_valid_r <= 1'b0;
      end else begin
        out_valid_r <= in_acc && res_valid;
      end
    end else if (in_acc && res_valid) begin
      skid_valid_r <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (out_take || !out_valid_r) begin
      if (skid_valid_r) begin
        out_r <= skid_r;
      end else if (in_acc && res_valid) begin
        out_r <= res;
      end
    end else if (in_acc && res_valid) begin
      skid_r <= res;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_kind         = out_r.kind;
  assign out_frame_opcode = out_r.frame_opcode;
  assign out_frame_length = out_r.frame_length;
  assign out_payload_byte = out_r.payload_byte;
  assign out_last         = out_r.last;

endmodule

@@ tb/sv/testbench.sv @@
// Self-checking testbench for the WebSocket frame deframer unit.
`timescale 1ns / 1ps

module testbench;

  localparam logic [6:0] LEN7_EXT64 = 7'd127;
  localparam int RANDOM_BYTES   = 1550;
  localparam int QUIET_START    = 300;
  localparam int QUIET_END      = 900;
  localparam int IDLE_PERCENT   = 11;
  localparam int DRAIN_CYCLES   = 8;
  localparam int WATCHDOG_LIMIT = 1000;

  typedef struct packed {
    logic [7:0]        data;
    logic              typed;
    wsfd_pkg::result_t want;
  } stim_row_t;

  localparam wsfd_pkg::result_t NO_RESULT = '0;

  // Short hand-picked frames; typed rows carry the result the byte must cause.
  localparam stim_row_t OPENING [23] = '{
    // unmasked one-byte frame straight after reset
    '{8'h81, 1'b0, NO_RESULT},
    '{8'h01, 1'b1, '{wsfd_pkg::KIND_HEADER, 4'd1, 63'd1, 8'd0, 1'b0}},
    '{8'h41, 1'b0, NO_RESULT},
    // empty payload, highest opcode
    '{8'h8F, 1'b0, NO_RESULT},
    '{8'h00, 1'b1, '{wsfd_pkg::KIND_HEADER, 4'd15, 63'd0, 8'd0, 1'b1}},
    // FIN clear with reserved bits set: error, payload dropped
    '{8'h70, 1'b0, NO_RESULT},
    '{8'h01, 1'b1, '{wsfd_pkg::KIND_ERROR, 4'd0, 63'd1, 8'd0, 1'b1}},
    '{8'hFF, 1'b0, NO_RESULT},
    // masked frame, key wraps after four payload bytes
    '{8'h82, 1'b0, NO_RESULT},
    '{8'h85, 1'b0, NO_RESULT},
    '{8'hFF, 1'b0, NO_RESULT},
    '{8'h00, 1'b0, NO_RESULT},
    '{8'hA5, 1'b0, NO_RESULT},
    '{8'h5A, 1'b1, '{wsfd_pkg::KIND_HEADER, 4'd2, 63'd5, 8'd0, 1'b0}},
    '{8'h00, 1'b0, NO_RESULT},
    '{8'hFF, 1'b0, NO_RESULT},
    '{8'h12, 1'b0, NO_RESULT},
    '{8'h34, 1'b0, NO_RESULT},
    '{8'h56, 1'b0, NO_RESULT},
    // 16-bit extension holding a zero length
    '{8'h89, 1'b0, NO_RESULT},
    '{8'h7E, 1'b0, NO_RESULT},
    '{8'h00, 1'b0, NO_RESULT},
    '{8'h00, 1'b1, '{wsfd_pkg::KIND_HEADER, 4'd9, 63'd0, 8'd0, 1'b1}}
  };

  // Largest length with the reserved top bit set; its payload never arrives.
  localparam stim_row_t TAIL [10] = '{
    '{8'h8A, 1'b0, NO_RESULT},
    '{8'h7F, 1'b0, NO_RESULT},
    '{8'hFF, 1'b0, NO_RESULT},
    '{8'hFF, 1'b0, NO_RESULT},
    '{8'hFF, 1'b0, NO_RESULT},
    '{8'hFF, 1'b0, NO_RESULT},
    '{8'hFF, 1'b0, NO_RESULT},
    '{8'hFF, 1'b0, NO_RESULT},
    '{8'hFF, 1'b0, NO_RESULT},
    '{8'hFF, 1'b1, '{wsfd_pkg::KIND_HEADER, 4'd10, 63'h7FFF_FFFF_FFFF_FFFF, 8'd0, 1'b0}}
  };

  logic        clk;
  logic        rst_n        = 1'b0;
  logic        in_valid     = 1'b0;
  logic        in_stall;
  logic [7:0]  in_data_byte = 8'd0;
  logic        out_valid;
  logic        out_stall    = 1'b0;
  logic [1:0]  out_kind;
  logic [3:0]  out_frame_opcode;
  logic [62:0] out_frame_length;
  logic [7:0]  out_payload_byte;
  logic        out_last;

  websocket_frame_deframer_unit DUT (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_data_byte     (in_data_byte),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_kind         (out_kind),
    .out_frame_opcode (out_frame_opcode),
    .out_frame_length (out_frame_length),
    .out_payload_byte (out_payload_byte),
    .out_last         (out_last)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  stim_row_t         stream_q[$];
  stim_row_t         bus_row = '0;
  wsfd_pkg::result_t expected_q[$];

  int fail_count    = 0;
  int cycle_n       = 0;
  int quiet_cycles  = 0;
  int bytes_sent    = 0;
  int results_seen  = 0;
  int frames_random = 0;
  int frames_nofin  = 0;
  int frames_masked = 0;
  int frames_ext    = 0;

  // Parser state mirrored from the block
  wsfd_pkg::phase_t st_phase     = wsfd_pkg::PH_FIRST;
  logic [3:0]       st_left      = '0;
  logic [3:0]       st_opcode    = '0;
  logic             st_masked    = 1'b0;
  logic             st_fin_err   = 1'b0;
  logic [31:0]      st_key       = '0;
  logic [63:0]      st_length    = '0;
  logic [63:0]      st_remaining = '0;
  logic [1:0]       st_key_idx   = '0;

  task automatic log_mismatch(input string msg);
    $display("[%0t] MISMATCH: %s", $realtime, msg);
    fail_count++;
  endtask

  task automatic header_done(output bit hit, output wsfd_pkg::result_t r);
    st_length[63] = 1'b0;
    if (st_length[62:0] > wsfd_pkg::LEN_LIMIT) st_length = 64'(wsfd_pkg::LEN_LIMIT);
    st_remaining = st_length;
    st_key_idx   = '0;
    st_left      = '0;
    st_phase     = (st_remaining != 0) ? wsfd_pkg::PH_PAYLOAD : wsfd_pkg::PH_FIRST;
    hit = 1'b1;
    r.kind         = st_fin_err ? wsfd_pkg::KIND_ERROR : wsfd_pkg::KIND_HEADER;
    r.frame_opcode = st_opcode;
    r.frame_length = st_length[62:0];
    r.payload_byte = '0;
    r.last         = st_fin_err || (st_remaining == 0);
  endtask

  task automatic length_done(output bit hit, output wsfd_pkg::result_t r);
    hit = 1'b0;
    r   = '0;
    if (st_masked) begin
      st_phase = wsfd_pkg::PH_KEY;
      st_left  = wsfd_pkg::KEY_BYTES;
    end else begin
      header_done(hit, r);
    end
  endtask

  // Advance the parser by one stream byte; hit flags a result.
  task automatic deframe_byte(input logic [7:0] b, output bit hit,
                              output wsfd_pkg::result_t r);
    logic [7:0] key_byte;
    hit = 1'b0;
    r   = '0;
    case (st_phase)
      wsfd_pkg::PH_SECOND: begin
        st_masked = b[7];
        st_key    = '0;
        if (b[6:0] <= wsfd_pkg::LEN7_MAX_SHORT) begin
          st_length = 64'(b[6:0]);
          length_done(hit, r);
        end else begin
          st_length = '0;
          st_left   = (b[6:0] == wsfd_pkg::LEN7_EXT16) ? wsfd_pkg::EXT16_BYTES
                                                       : wsfd_pkg::EXT64_BYTES;
          st_phase  = wsfd_pkg::PH_EXT;
        end
      end
      wsfd_pkg::PH_EXT: begin
        st_length = {st_length[55:0], b};
        st_left   = st_left - 4'd1;
        if (st_left == 0) length_done(hit, r);
      end
      wsfd_pkg::PH_KEY: begin
        st_key  = {st_key[23:0], b};
        st_left = st_left - 4'd1;
        if (st_left == 0) header_done(hit, r);
      end
      wsfd_pkg::PH_PAYLOAD: begin
        key_byte     = st_key[8 * (3 - st_key_idx) +: 8];
        st_remaining = st_remaining - 64'd1;
        st_key_idx   = st_key_idx + 2'd1;
        if (st_remaining == 0) st_phase = wsfd_pkg::PH_FIRST;
        if (!st_fin_err) begin
          hit = 1'b1;
          r.kind         = wsfd_pkg::KIND_DATA;
          r.frame_opcode = st_opcode;
          r.frame_length = st_length[62:0];
          r.payload_byte = b ^ key_byte;
          r.last         = (st_remaining == 0);
        end
      end
      default: begin
        st_fin_err   = ~b[7];
        st_opcode    = b[3:0];
        st_masked    = 1'b0;
        st_key       = '0;
        st_length    = '0;
        st_remaining = '0;
        st_key_idx   = '0;
        st_left      = '0;
        st_phase     = wsfd_pkg::PH_SECOND;
      end
    endcase
  endtask

  task automatic check_result(input wsfd_pkg::result_t got, input wsfd_pkg::result_t want);
    if (got.kind !== want.kind)
      log_mismatch($sformatf("kind %0d, expected %0d", got.kind, want.kind));
    if (got.frame_opcode !== want.frame_opcode)
      log_mismatch($sformatf("opcode %0h, expected %0h", got.frame_opcode, want.frame_opcode));
    if (got.frame_length !== want.frame_length)
      log_mismatch($sformatf("length %0h, expected %0h", got.frame_length, want.frame_length));
    if (got.payload_byte !== want.payload_byte)
      log_mismatch($sformatf("payload %02h, expected %02h", got.payload_byte, want.payload_byte));
    if (got.last !== want.last)
      log_mismatch($sformatf("last %0b, expected %0b", got.last, want.last));
  endtask

  task automatic push_byte(input logic [7:0] b);
    stream_q.push_back('{data: b, typed: 1'b0, want: NO_RESULT});
  endtask

  // Frame with random flags, key, payload and length encoding; bit 63 of a 64-bit length is random.
  task automatic queue_random_frame();
    bit          fin;
    bit          masked;
    int unsigned len;
    int unsigned pick;
    int          n_ext;
    logic [6:0]  len7;
    logic [63:0] ext;
    fin    = ($urandom_range(99) >= 12);
    masked = 1'($urandom_range(1));
    pick   = $urandom_range(99);
    if (pick < 8) len = 0;
    else if (pick < 80) len = $urandom_range(24, 1);
    else if (pick < 95) len = $urandom_range(125, 25);
    else len = $urandom_range(400, 126);
    pick = $urandom_range(99);
    if (len <= 125 && pick < 60) begin
      len7  = 7'(len);
      n_ext = 0;
    end else if (pick < 80) begin
      len7  = wsfd_pkg::LEN7_EXT16;
      n_ext = 2;
    end else begin
      len7  = LEN7_EXT64;
      n_ext = 8;
    end
    ext = 64'(len);
    if (n_ext == 8) ext[63] = 1'($urandom_range(1));
    push_byte({fin, 3'($urandom), 4'($urandom)});
    push_byte({masked, len7});
    for (int i = n_ext - 1; i >= 0; i--) push_byte(ext[8 * i +: 8]);
    if (masked) repeat (4) push_byte(8'($urandom));
    repeat (len) push_byte(8'($urandom));
    frames_random++;
    if (!fin) frames_nofin++;
    if (masked) frames_masked++;
    if (n_ext != 0) frames_ext++;
  endtask

  always @(posedge clk) begin : drive_and_check
    bit                hit;
    bit                moved;
    bit                noisy;
    wsfd_pkg::result_t pred;
    wsfd_pkg::result_t got;
    moved = 1'b0;
    if (rst_n) begin
      cycle_n++;
      noisy = !(cycle_n >= QUIET_START && cycle_n < QUIET_END);
      if (out_valid && !out_stall) begin
        moved = 1'b1;
        got.kind         = wsfd_pkg::kind_t'(out_kind);
        got.frame_opcode = out_frame_opcode;
        got.frame_length = out_frame_length;
        got.payload_byte = out_payload_byte;
        got.last         = out_last;
        if (expected_q.size() == 0)
          log_mismatch($sformatf("unexpected result kind %0d", out_kind));
        else
          check_result(got, expected_q.pop_front());
        results_seen++;
      end
      if (in_valid && !in_stall) begin
        moved = 1'b1;
        deframe_byte(in_data_byte, hit, pred);
        if (bus_row.typed) expected_q.push_back(bus_row.want);
        else if (hit) expected_q.push_back(pred);
        bytes_sent++;
      end
      // Hold a stalled item; otherwise offer the next one or idle.
      if (!in_valid || !in_stall) begin
        if (stream_q.size() != 0 && !(noisy && $urandom_range(99) < IDLE_PERCENT)) begin
          bus_row = stream_q.pop_front();
          in_valid     <= 1'b1;
          in_data_byte <= bus_row.data;
        end else begin
          in_valid <= 1'b0;
        end
      end
      out_stall <= noisy && ($urandom_range(99) < IDLE_PERCENT);
      quiet_cycles = moved ? 0 : quiet_cycles + 1;
    end
  end

  initial begin
    foreach (OPENING[i]) stream_q.push_back(OPENING[i]);
    while (stream_q.size() < RANDOM_BYTES) queue_random_frame();
    foreach (TAIL[i]) stream_q.push_back(TAIL[i]);
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    while (stream_q.size() != 0 || in_valid || expected_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    $display("Sent %0d stream bytes: %0d random frames (%0d FIN clear, %0d masked, %0d extended).",
             bytes_sent, frames_random, frames_nofin, frames_masked, frames_ext);
    $display("Checked %0d results, %0d field mismatches.", results_seen, fail_count);
    if (fail_count == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

  initial begin
    while (quiet_cycles < WATCHDOG_LIMIT) @(posedge clk);
    $display("Timeout: no handshake for %0d cycles, %0d results outstanding.",
             WATCHDOG_LIMIT, expected_q.size());
    $display("Test completed with failures");
    $finish;
  end

endmodule
